@@ sv/aes128_pkg.sv @@
// Package with AES-128 tables, round functions and shared types.
package aes128_pkg;

    localparam int Rounds = 10;
    localparam int KeyWords = Rounds + 1;
    localparam int QueueDepth = 2;
    localparam int PipeDepth = Rounds + 1;

    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    localparam logic [0:0] RegKeyHigh = 1'b0;
    localparam logic [0:0] RegKeyLow = 1'b1;

    typedef logic [127:0] t_block;
    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic   decrypt;
        t_block data;
    } t_word;

    function automatic t_byte fwd_sbox(input t_byte x);
        t_byte tab [256];
        tab = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tab[x];
    endfunction

    function automatic t_byte inv_sbox(input t_byte x);
        t_byte tab [256];
        tab = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return tab[x];
    endfunction

    function automatic t_byte xtime(input t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte get_byte(input t_block b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block b, input logic inv);
        t_block o;
        int src;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    src = ((c - r + 4) & 3) * 4 + r;
                    o[127 - 8 * (c * 4 + r) -: 8] = inv_sbox(get_byte(b, src));
                end else begin
                    src = ((c + r) & 3) * 4 + r;
                    o[127 - 8 * (c * 4 + r) -: 8] = fwd_sbox(get_byte(b, src));
                end
            end
        end
        return o;
    endfunction

    function automatic t_block mix(input t_block b, input logic inv);
        t_block o;
        t_byte a [4];
        t_byte a2 [4];
        t_byte a4 [4];
        t_byte a8 [4];
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = get_byte(b, c * 4 + r);
                a2[r] = xtime(a[r]);
                a4[r] = xtime(a2[r]);
                a8[r] = xtime(a4[r]);
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    o[127 - 8 * (c * 4 + r) -: 8] =
                        (a8[r] ^ a4[r] ^ a2[r]) ^
                        (a8[(r + 1) & 3] ^ a2[(r + 1) & 3] ^ a[(r + 1) & 3]) ^
                        (a8[(r + 2) & 3] ^ a4[(r + 2) & 3] ^ a[(r + 2) & 3]) ^
                        (a8[(r + 3) & 3] ^ a[(r + 3) & 3]);
                end else begin
                    o[127 - 8 * (c * 4 + r) -: 8] = a2[r] ^ a2[(r + 1) & 3] ^
                        a[(r + 1) & 3] ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
                end
            end
        end
        return o;
    endfunction

endpackage

@@ sv/aes128_block_cipher_unit.sv @@
// Top level of the AES-128 ECB cipher unit.
// Channel | Direction | Signals
// input   | in        | i_valid, o_ready, i_command, i_block_high, i_block_low
// output  | out       | o_valid, i_ready, o_result_high, o_result_low
// config  | in        | i_cfg_we, i_cfg_index, i_cfg_data
// One block enters per cycle when not stalled; after it is accepted it passes through
// the queue, the key add and 10 rounds. The ten unrolled round stages give one block per cycle when not stalled.
// All stages stall together on output; the two-word queue then fills and stalls input.
// Reset is synchronous and clears valid state; round keys need a key write first.
// After a key write the schedule expands one round key per cycle, and blocks wait
// in the queue until it is complete.
module aes128_block_cipher_unit
    import aes128_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [63:0] r_key_hi;
    logic [63:0] r_key_lo;
    logic r_start;
    t_block w_keys [KeyWords];
    logic w_kbusy;
    t_word w_q;
    logic w_qv;
    logic w_qr;
    t_block w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegKeyHigh: r_key_hi <= i_cfg_data;
                    RegKeyLow: r_key_lo <= i_cfg_data;
                    default: r_key_lo <= r_key_lo;
                endcase
            end
        end
    end

    aes128_keyexp u_keyexp (
        .i_clk, .i_rst_n, .i_start(r_start), .i_key({r_key_hi, r_key_lo}), .o_keys(w_keys),
        .o_busy(w_kbusy)
    );

    aes128_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_word('{decrypt: i_command, data: {i_block_high, i_block_low}}),
        .o_valid(w_qv), .i_ready(w_qr && !w_kbusy), .o_word(w_q)
    );

    aes128_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv && !w_kbusy), .o_ready(w_qr), .i_word(w_q),
        .i_keys(w_keys), .o_valid, .i_ready, .o_data(w_res)
    );

    assign o_result_high = w_res[127:64];
    assign o_result_low = w_res[63:0];
endmodule

@@ sv/aes128_keyexp.sv @@
// Key schedule unit: expands one round key per cycle into a register file.
module aes128_keyexp
    import aes128_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_block i_key,
    output t_block o_keys [KeyWords],
    output logic   o_busy
);
    localparam int CntW = $clog2(KeyWords + 1);

    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    t_block r_cur;
    t_byte r_rc;
    t_block r_keys [KeyWords];
    t_block n_next;
    logic [31:0] w_rot;
    logic [31:0] w_t;

    always_comb begin
        w_rot = {r_cur[23:0], r_cur[31:24]};
        w_t = {fwd_sbox(w_rot[31:24]) ^ r_rc, fwd_sbox(w_rot[23:16]),
               fwd_sbox(w_rot[15:8]), fwd_sbox(w_rot[7:0])};
        n_next[127:96] = r_cur[127:96] ^ w_t;
        n_next[95:64] = r_cur[95:64] ^ n_next[127:96];
        n_next[63:32] = r_cur[63:32] ^ n_next[95:64];
        n_next[31:0] = r_cur[31:0] ^ n_next[63:32];
        n_cnt = r_cnt;
        if (i_start) begin
            n_cnt = CntW'(1);
        end else if (r_cnt != '0 && r_cnt != CntW'(KeyWords)) begin
            n_cnt = r_cnt + CntW'(1);
        end else begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_cur <= i_key;
            r_rc <= 8'h01;
            r_keys[0] <= i_key;
        end else if (r_cnt != '0 && r_cnt != CntW'(KeyWords)) begin
            r_cur <= n_next;
            r_rc <= xtime(r_rc);
            r_keys[r_cnt[$clog2(KeyWords)-1:0]] <= n_next;
        end
    end

    assign o_keys = r_keys;
    assign o_busy = i_start || (r_cnt != '0 && r_cnt != CntW'(KeyWords));
endmodule

@@ sv/aes128_front.sv @@
// Front end: a short two-word queue ahead of the round pipeline.
module aes128_front
    import aes128_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_word,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_word
);
    localparam int PtrW = $clog2(QueueDepth);

    t_word r_mem [QueueDepth];
    logic [PtrW-1:0] r_wp;
    logic [PtrW-1:0] r_rp;
    logic [PtrW:0] r_cnt;
    logic w_push;
    logic w_pop;

    assign o_ready = r_cnt != (PtrW+1)'(QueueDepth);
    assign o_valid = r_cnt != '0;
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;
    assign o_word = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + PtrW'(1);
            if (w_pop) r_rp <= r_rp + PtrW'(1);
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_word;
    end
endmodule

@@ sv/aes128_back.sv @@
// Back end: fully unrolled round pipeline with stall; the last stage drives the output.
module aes128_back
    import aes128_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_word  i_word,
    input  t_block i_keys [KeyWords],
    output logic   o_valid,
    input  logic   i_ready,
    output t_block o_data
);
    logic   r_v [PipeDepth];
    t_word  r_s [PipeDepth];
    logic   w_adv;
    t_block w_in;

    assign w_adv = !r_v[PipeDepth-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[PipeDepth-1];
    assign o_data = r_s[PipeDepth-1].data;
    assign w_in = i_word.data ^ (i_word.decrypt ? i_keys[Rounds] : i_keys[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PipeDepth; k++) r_v[k] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < PipeDepth; k++) r_v[k] <= r_v[k-1];
        end
        if (w_adv) begin
            r_s[0] <= '{decrypt: i_word.decrypt, data: w_in};
        end
    end

    for (genvar g = 1; g < PipeDepth; g++) begin : g_round
        t_block w_ss;
        t_block w_out;
        always_comb begin
            w_ss = sub_shift(r_s[g-1].data, r_s[g-1].decrypt);
            if (r_s[g-1].decrypt) begin
                w_out = w_ss ^ i_keys[Rounds - g];
                if (g != Rounds) w_out = mix(w_out, 1'b1);
            end else begin
                w_out = w_ss;
                if (g != Rounds) w_out = mix(w_out, 1'b0);
                w_out = w_out ^ i_keys[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) r_s[g] <= '{decrypt: r_s[g-1].decrypt, data: w_out};
        end
    end
endmodule

@@ sv/aes128_checker.sv @@
// Port-level checker for the cipher unit, bound to the top level.
module aes128_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_high) && $stable(o_result_low))
        else $error("result changed while stalled");
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");
    a_ready_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("not ready after reset");
endmodule

bind aes128_block_cipher_unit aes128_checker u_checker (.*);
